>>> src/ptiu_pkg.sv
package ptiu_pkg;

	// Field widths of one request: six Q16.16 values and two Q8.16 times.
	localparam int unsigned VW    = 32;
	localparam int unsigned TW    = 24;
	localparam int unsigned IN_W  = 6 * VW + 2 * TW;
	localparam int unsigned OUT_W = 3 * VW;

	localparam logic [1:0] MODE_QUINTIC = 2'd0;
	localparam logic [1:0] MODE_CUBIC   = 2'd1;

	// What the back end has to do with a queued request.
	typedef enum logic [1:0] {KIND_QUIN, KIND_CUB, KIND_LIN, KIND_END} kind_t;

	// Right shift applied after a product.
	typedef enum logic [1:0] {SH_0, SH_16, SH_32, SH_33} sh_t;

	// Clamp applied to a quotient magnitude.
	typedef enum logic {LIM_31, LIM_62} lim_t;

	typedef struct packed {
		kind_t                kind;
		logic signed [VW-1:0] sp;
		logic signed [VW-1:0] sv;
		logic signed [VW-1:0] sa;
		logic signed [VW-1:0] ep;
		logic signed [VW-1:0] ev;
		logic signed [VW-1:0] ea;
		logic [TW-1:0]        dur;
		logic [TW-1:0]        tim;
	} item_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic [31:0]        b;
		sh_t                sh;
	} mul_req_t;

	typedef struct packed {
		logic          start;
		logic [63:0]   num_mag;
		logic          neg;
		logic [TW-1:0] den;
		lim_t          lim;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] y;
	} op_rsp_t;

endpackage

>>> src/ptiu_front.sv
module ptiu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ptiu_pkg::IN_W-1:0]  s_tdata,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_wdata,
	output logic                       q_valid,
	output ptiu_pkg::item_t            q_item,
	input  logic                       q_pop
);
	import ptiu_pkg::*;

	logic [1:0] mode_q;
	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// Unpack the request and decide what the back end must do with it.
	// Requests at or past the segment end carry their final values already.
	always_comb begin
		cls.sp  = s_tdata[0*VW +: VW];
		cls.sv  = s_tdata[1*VW +: VW];
		cls.sa  = s_tdata[2*VW +: VW];
		cls.ep  = s_tdata[3*VW +: VW];
		cls.ev  = s_tdata[4*VW +: VW];
		cls.ea  = s_tdata[5*VW +: VW];
		cls.dur = s_tdata[6*VW +: TW];
		cls.tim = s_tdata[6*VW+TW +: TW];
		if (cls.tim >= cls.dur) begin
			cls.kind = KIND_END;
			if (!(mode_q == MODE_QUINTIC || mode_q == MODE_CUBIC)) begin
				cls.ev = '0;
			end
			if (mode_q != MODE_QUINTIC) begin
				cls.ea = '0;
			end
		end else begin
			case (mode_q)
				MODE_QUINTIC: cls.kind = KIND_QUIN;
				MODE_CUBIC:   cls.kind = KIND_CUB;
				default:      cls.kind = KIND_LIN;
			endcase
		end
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid & s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_QUINTIC;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

endmodule

>>> src/ptiu_mul.sv
module ptiu_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  ptiu_pkg::mul_req_t  req,
	output ptiu_pkg::op_rsp_t   rsp
);
	import ptiu_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [31:0]        ahi_s1, b_s1;
	logic [63:0]        pl_s1, pl_s2, ph_s2;
	logic [95:0]        prod_s3;
	logic               neg_s1, neg_s2, neg_s3;
	sh_t                sh_s1, sh_s2, sh_s3;
	logic signed [63:0] y_s4;
	logic [63:0]        a_mag;
	logic [95:0]        shv, magr;
	logic               lost;
	logic signed [63:0] ysat;

	assign a_mag = req.a[63] ? (~req.a + 64'd1) : req.a;

	// Floor of the signed product, then saturation to 64 bits.
	always_comb begin
		case (sh_s3)
			SH_16: begin
				shv  = prod_s3 >> 16;
				lost = |prod_s3[15:0];
			end
			SH_32: begin
				shv  = prod_s3 >> 32;
				lost = |prod_s3[31:0];
			end
			SH_33: begin
				shv  = prod_s3 >> 33;
				lost = |prod_s3[32:0];
			end
			default: begin
				shv  = prod_s3;
				lost = 1'b0;
			end
		endcase
		magr = shv + 96'(neg_s3 & lost);
		if (!neg_s3) begin
			ysat = (|shv[95:63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : shv[63:0];
		end else begin
			ysat = (|magr[95:63]) ? 64'sh8000_0000_0000_0000 : (~magr[63:0] + 64'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pl_s1   <= 64'(a_mag[31:0]) * 64'(req.b);
		ahi_s1  <= a_mag[63:32];
		b_s1    <= req.b;
		neg_s1  <= req.a[63];
		sh_s1   <= req.sh;
		ph_s2   <= 64'(ahi_s1) * 64'(b_s1);
		pl_s2   <= pl_s1;
		neg_s2  <= neg_s1;
		sh_s2   <= sh_s1;
		prod_s3 <= {ph_s2, 32'd0} + 96'(pl_s2);
		neg_s3  <= neg_s2;
		sh_s3   <= sh_s2;
		y_s4    <= ysat;
	end

	assign rsp.done = v_s4;
	assign rsp.y    = y_s4;

endmodule

>>> src/ptiu_div.sv
module ptiu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ptiu_pkg::div_req_t  req,
	output ptiu_pkg::op_rsp_t   rsp
);
	import ptiu_pkg::*;

	localparam int unsigned DQ_W  = 64 + 16;
	localparam int unsigned CNT_W = $clog2(DQ_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DQ_W-1:0]    dq_q;
	logic [TW-1:0]      rem_q, den_q;
	logic               neg_q;
	lim_t               lim_q;
	logic signed [63:0] y_q;
	logic [TW:0]        rem2;
	logic               ge;
	logic [DQ_W-1:0]    limv;
	logic [63:0]        resv;

	// One quotient bit per cycle; the dividend register fills with quotient bits.
	assign rem2 = {rem_q, dq_q[DQ_W-1]};
	assign ge   = (rem2 >= {1'b0, den_q});
	assign limv = (lim_q == LIM_31) ? (DQ_W'(1) << 31) : (DQ_W'(1) << 62);
	assign resv = (dq_q > limv) ? limv[63:0] : dq_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DQ_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= {req.num_mag, 16'd0};
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.neg;
			lim_q <= req.lim;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				dq_q  <= {dq_q[DQ_W-2:0], ge};
				rem_q <= ge ? TW'(rem2 - {1'b0, den_q}) : TW'(rem2);
			end else begin
				y_q <= neg_q ? (~resv + 64'd1) : resv;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule

>>> src/ptiu_back.sv
module ptiu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  ptiu_pkg::item_t            q_item,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ptiu_pkg::OUT_W-1:0] m_tdata
);
	import ptiu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SDIV, ST_LMUL, ST_LDIV, ST_XMUL, ST_MIX,
		ST_HORN, ST_VDIV, ST_ADIV1, ST_ADIV2, ST_FIN
	} st_t;
	typedef enum logic [1:0] {PASS_P, PASS_Q, PASS_R} pass_t;
	typedef logic [4:0][4:0] kvec_t;

	// Coefficient weights over (D, V0, V1, Ah0, Ah1); D is entry 0, the last one listed.
	localparam kvec_t K3Q = {5'd1, -5'd3, -5'd4, -5'd6, 5'd10};
	localparam kvec_t K4Q = {-5'd2, 5'd3, 5'd7, 5'd8, -5'd15};
	localparam kvec_t K5Q = {5'd1, -5'd1, -5'd3, -5'd3, 5'd6};
	localparam kvec_t K2C = {5'd0, 5'd0, -5'd1, -5'd2, 5'd3};
	localparam kvec_t K3C = {5'd0, 5'd0, 5'd1, 5'd1, -5'd2};

	st_t                st_q;
	logic               issued_q;
	logic [2:0]         idx_q;
	pass_t              pass_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	item_t              it_q;
	logic [31:0]        s_q;
	logic signed [63:0] d_q, x1_q, x2_q, x3_q, x4_q, tmp_q, h_q;
	logic signed [63:0] c_q [6];
	logic signed [63:0] pos_q, vel_q, acc_q;

	mul_req_t           mreq;
	div_req_t           dreq;
	op_rsp_t            mul_rsp, div_rsp;
	logic               op_done;
	logic               out_free;
	logic signed [63:0] c2n, c3n, c4n, c5n, hn;
	logic [4:0][63:0]   xv;

	function automatic logic signed [63:0] sx(input logic [VW-1:0] v);
		return {{(64-VW){v[VW-1]}}, v};
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
	                                            input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] mul_small(input logic signed [63:0] a,
	                                                 input logic [4:0] k);
		return a * $signed({59'd0, k});
	endfunction

	function automatic logic signed [63:0] mix(input logic [4:0][63:0] x, input kvec_t k);
		logic signed [63:0] acc;
		acc = '0;
		for (int i = 0; i < 5; i++) begin
			acc = acc + $signed(x[i]) * 64'($signed(k[i]));
		end
		return acc;
	endfunction

	function automatic logic [2:0] low_idx(input pass_t p);
		case (p)
			PASS_P:  return 3'd0;
			PASS_Q:  return 3'd1;
			default: return 3'd2;
		endcase
	endfunction

	// Weight of coefficient i in the polynomial, its derivative or its second derivative.
	function automatic logic [4:0] fac(input pass_t p, input logic [2:0] i);
		case (p)
			PASS_P:  return 5'd1;
			PASS_Q:  return 5'(i);
			default: return 5'(i) * (5'(i) - 5'd1);
		endcase
	endfunction

	function automatic logic [VW-1:0] sat_out(input logic signed [63:0] v);
		if (v[63:VW-1] == '0 || v[63:VW-1] == '1) begin
			return v[VW-1:0];
		end
		return v[63] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	endfunction

	ptiu_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mul_rsp));
	ptiu_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(div_rsp));

	assign op_done  = mul_rsp.done | div_rsp.done;
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = (st_q == ST_IDLE) && q_valid;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		mreq.start = !issued_q && (st_q == ST_LMUL || st_q == ST_XMUL || st_q == ST_HORN);
		mreq.a     = h_q;
		mreq.b     = s_q;
		mreq.sh    = SH_32;
		case (st_q)
			ST_LMUL: mreq.a = d_q;
			ST_XMUL: begin
				mreq.b = 32'(it_q.dur);
				case (idx_q)
					3'd0: begin
						mreq.a  = sx(it_q.sv);
						mreq.sh = SH_16;
					end
					3'd1: begin
						mreq.a  = sx(it_q.ev);
						mreq.sh = SH_16;
					end
					3'd2: begin
						mreq.a  = sx(it_q.sa);
						mreq.sh = SH_0;
					end
					3'd4: begin
						mreq.a  = sx(it_q.ea);
						mreq.sh = SH_0;
					end
					default: begin
						mreq.a  = tmp_q;
						mreq.sh = SH_33;
					end
				endcase
			end
			default: mreq.a = h_q;
		endcase
	end

	always_comb begin
		dreq.start   = !issued_q && (st_q == ST_SDIV || st_q == ST_LDIV ||
		               st_q == ST_VDIV || st_q == ST_ADIV1 || st_q == ST_ADIV2);
		dreq.den     = it_q.dur;
		dreq.num_mag = mag64(acc_q);
		dreq.neg     = acc_q[63];
		dreq.lim     = LIM_31;
		case (st_q)
			ST_SDIV: begin
				dreq.num_mag = 64'(it_q.tim) << 16;
				dreq.neg     = 1'b0;
				dreq.lim     = LIM_62;
			end
			ST_LDIV: begin
				dreq.num_mag = mag64(d_q);
				dreq.neg     = d_q[63];
			end
			ST_VDIV: begin
				dreq.num_mag = mag64(vel_q);
				dreq.neg     = vel_q[63];
			end
			ST_ADIV1: dreq.lim = LIM_62;
			default:  dreq.lim = LIM_31;
		endcase
	end

	assign xv = {x4_q, x3_q, x2_q, x1_q, d_q};

	always_comb begin
		if (it_q.kind == KIND_QUIN) begin
			c2n = x3_q;
			c3n = mix(xv, K3Q);
			c4n = mix(xv, K4Q);
			c5n = mix(xv, K5Q);
		end else begin
			c2n = mix(xv, K2C);
			c3n = mix(xv, K3C);
			c4n = '0;
			c5n = '0;
		end
		hn = sadd(mul_small(c_q[idx_q], fac(pass_q, idx_q)), mul_rsp.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			issued_q   <= 1'b0;
			idx_q      <= '0;
			pass_q     <= PASS_P;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			issued_q <= (issued_q | mreq.start | dreq.start) & !op_done;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q <= (q_item.kind == KIND_END) ? ST_FIN : ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (div_rsp.done) begin
						st_q  <= (it_q.kind == KIND_LIN) ? ST_LMUL : ST_XMUL;
						idx_q <= '0;
					end
				end
				ST_LMUL: begin
					if (mul_rsp.done) begin
						st_q <= ST_LDIV;
					end
				end
				ST_LDIV: begin
					if (div_rsp.done) begin
						st_q <= ST_FIN;
					end
				end
				ST_XMUL: begin
					if (mul_rsp.done) begin
						if ((it_q.kind == KIND_CUB && idx_q == 3'd1) || idx_q == 3'd5) begin
							st_q <= ST_MIX;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_MIX: begin
					st_q   <= ST_HORN;
					pass_q <= PASS_P;
					idx_q  <= 3'd4;
				end
				ST_HORN: begin
					if (mul_rsp.done) begin
						if (idx_q == low_idx(pass_q)) begin
							idx_q <= 3'd4;
							case (pass_q)
								PASS_P: pass_q <= PASS_Q;
								PASS_Q: begin
									if (it_q.kind == KIND_QUIN) begin
										pass_q <= PASS_R;
									end else begin
										st_q <= ST_VDIV;
									end
								end
								default: st_q <= ST_VDIV;
							endcase
						end else begin
							idx_q <= idx_q - 3'd1;
						end
					end
				end
				ST_VDIV: begin
					if (div_rsp.done) begin
						st_q <= (it_q.kind == KIND_QUIN) ? ST_ADIV1 : ST_FIN;
					end
				end
				ST_ADIV1: begin
					if (div_rsp.done) begin
						st_q <= ST_ADIV2;
					end
				end
				ST_ADIV2: begin
					if (div_rsp.done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {sat_out(acc_q), sat_out(vel_q), sat_out(pos_q)};
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					it_q  <= q_item;
					d_q   <= sx(q_item.ep) - sx(q_item.sp);
					x3_q  <= '0;
					x4_q  <= '0;
					pos_q <= sx(q_item.ep);
					vel_q <= sx(q_item.ev);
					acc_q <= (q_item.kind == KIND_END) ? sx(q_item.ea) : '0;
				end
			end
			ST_SDIV: begin
				if (div_rsp.done) begin
					s_q <= div_rsp.y[31:0];
				end
			end
			ST_LMUL: begin
				if (mul_rsp.done) begin
					pos_q <= sadd(sx(it_q.sp), mul_rsp.y);
				end
			end
			ST_LDIV, ST_VDIV: begin
				if (div_rsp.done) begin
					vel_q <= div_rsp.y;
				end
			end
			ST_XMUL: begin
				if (mul_rsp.done) begin
					case (idx_q)
						3'd0:    x1_q  <= mul_rsp.y;
						3'd1:    x2_q  <= mul_rsp.y;
						3'd3:    x3_q  <= mul_rsp.y;
						3'd5:    x4_q  <= mul_rsp.y;
						default: tmp_q <= mul_rsp.y;
					endcase
				end
			end
			ST_MIX: begin
				c_q[0] <= sx(it_q.sp);
				c_q[1] <= x1_q;
				c_q[2] <= c2n;
				c_q[3] <= c3n;
				c_q[4] <= c4n;
				c_q[5] <= c5n;
				h_q    <= c5n;
			end
			ST_HORN: begin
				if (mul_rsp.done) begin
					if (idx_q == low_idx(pass_q)) begin
						case (pass_q)
							PASS_P: begin
								pos_q <= hn;
								h_q   <= mul_small(c_q[5], 5'd5);
							end
							PASS_Q: begin
								vel_q <= hn;
								h_q   <= mul_small(c_q[5], 5'd20);
							end
							default: acc_q <= hn;
						endcase
					end else begin
						h_q <= hn;
					end
				end
			end
			ST_ADIV1, ST_ADIV2: begin
				if (div_rsp.done) begin
					acc_q <= div_rsp.y;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.done && div_rsp.done))
		else $error("multiplier and divider finished in the same cycle");
	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		(mreq.start || dreq.start) |=> !(mreq.start || dreq.start))
		else $error("operation started twice in a row");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q == ST_SDIV || st_q == ST_FIN))
		else $error("popped request was not taken up");
`endif

endmodule

>>> src/polynomial_trajectory_interp_unit.sv
// A request at or past the segment end goes straight to the output; other requests run
// through the shared divider and multiplier in turn, with more steps in cubic and quintic mode.
// The back end works on one request at a time; a two-entry queue takes new requests
// meanwhile. Its steps run one at a time on the shared divider (one quotient bit per
// cycle) and the four-stage multiplier.
// Reset (arst_n low, asynchronous) empties the queue and output and sets quintic mode.
module polynomial_trajectory_interp_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// From bit 0: start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
	// duration, elapsed.
	input  logic [ptiu_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// From bit 0: pos_out, vel_out, acc_out.
	output logic [ptiu_pkg::OUT_W-1:0] m_tdata,
	// Writes interp_mode: 0 quintic, 1 cubic, 2 or 3 linear.
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_wdata
);
	import ptiu_pkg::*;

	// The front end unpacks each request, latches the mode it runs under and
	// resolves requests at or past the segment end. The back end sequences
	// the multiplier and divider over queued requests and holds one finished
	// result in its output register, while the queue lets the front end take requests ahead.
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	ptiu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ptiu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
